// ===== hw/rtl/mm4_pkg.sv =====
// shared widths, types and state codes for the matrix multiplier
`timescale 1ns / 1ps

package mm4_pkg;

   localparam int IDX_W   = 4;   // elem_index width
   localparam int VAL_W   = 32;  // q16.16 element width
   localparam int PROD_W  = 64;  // q32.32 product width
   localparam int RC_W    = 2;   // out_row / out_col width
   localparam int FRAC_W  = 16;  // fraction bits of q16.16

   localparam int REQ_DATA_W = 72;  // idx + a + b, padded to bytes
   localparam int RSP_DATA_W = 40;  // row + col + value, padded to bytes

   // sequencer states
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_RUN   = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;

   // control tag that travels with one multiply-accumulate step
   typedef struct packed {
      logic            valid;
      logic            first;   // first term of a dot product
      logic            last;    // last term of a dot product
      logic            run_end; // last term of the whole run
      logic [RC_W-1:0] row;
      logic [RC_W-1:0] col;
   } mm4_tag_type;

   // one finished product element
   typedef struct packed {
      logic             valid;
      logic             last;
      logic [RC_W-1:0]  row;
      logic [RC_W-1:0]  col;
      logic [VAL_W-1:0] value;
   } mm4_result_type;

endpackage

// ===== hw/rtl/mm4_store.sv =====
// element stores for matrices a and b, one write and one registered read each
`timescale 1ns / 1ps

module mm4_store
   import mm4_pkg::*;
#(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [VAL_W-1:0] wr_a,
   input  logic [VAL_W-1:0] wr_b,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_a_addr,
   input  logic [AW-1:0]    rd_b_addr,
   output logic [VAL_W-1:0] rd_a_data,
   output logic [VAL_W-1:0] rd_b_data
);

   logic [VAL_W-1:0] left_mem  [DEPTH];
   logic [VAL_W-1:0] right_mem [DEPTH];
   logic [VAL_W-1:0] rd_a_ff;
   logic [VAL_W-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         left_mem[wr_addr]  <= wr_a;
         right_mem[wr_addr] <= wr_b;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= left_mem[rd_a_addr];
         rd_b_ff <= right_mem[rd_b_addr];
      end
   end

   assign rd_a_data = rd_a_ff;
   assign rd_b_data = rd_b_ff;

endmodule

// ===== hw/rtl/mm4_mac.sv =====
// shared multiply-accumulate unit with q16.16 truncation and saturation
`timescale 1ns / 1ps

module mm4_mac
   import mm4_pkg::*;
#(
   parameter int DIM = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  mm4_tag_type           tag,
   input  logic signed [VAL_W-1:0] a_data,
   input  logic signed [VAL_W-1:0] b_data,
   output mm4_result_type        result
);

   localparam int ACC_W = PROD_W + $clog2(DIM);

   mm4_tag_type               tag_ff;
   mm4_tag_type               tag_in;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [PROD_W-1:0]  prod_in;
   logic signed [ACC_W-1:0]   acc_ff;
   logic signed [ACC_W-1:0]   acc_in;
   logic signed [ACC_W-1:0]   prod_ext;
   logic [ACC_W-1-(FRAC_W+VAL_W-1):0] acc_top;
   logic                      in_range;

   assign prod_in = adv ? (a_data * b_data) : prod_ff;

   always_comb begin
      tag_in = tag_ff;
      if (adv) begin
         tag_in = tag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
      end else begin
         tag_ff <= tag_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign prod_ext = ACC_W'(prod_ff);

   always_comb begin
      acc_in = acc_ff;
      if (adv && tag_ff.valid) begin
         acc_in = tag_ff.first ? prod_ext : (acc_ff + prod_ext);
      end
   end

   // sum fits q16.16 when all bits from bit 47 up agree
   assign acc_top  = acc_in[ACC_W-1:FRAC_W+VAL_W-1];
   assign in_range = (&acc_top) | ~(|acc_top);

   always_comb begin
      result.valid = tag_ff.valid && tag_ff.last;
      result.last  = tag_ff.run_end;
      result.row   = tag_ff.row;
      result.col   = tag_ff.col;
      if (in_range) begin
         result.value = acc_in[FRAC_W+VAL_W-1:FRAC_W];
      end else if (acc_in[ACC_W-1]) begin
         result.value = {1'b1, {(VAL_W-1){1'b0}}};
      end else begin
         result.value = {1'b0, {(VAL_W-1){1'b1}}};
      end
   end

endmodule

// ===== hw/rtl/matrix_multiply_4x4.sv =====
// a product leaves via the store read, product and output registers
// a run walks all DIM^3 terms through the single multiply-accumulate unit
// loads take one transfer per cycle; req_tready is low while products are computed
// rsp stalls freeze the whole unit pipeline; no load is taken until a run completes
// reset: synchronous, active high, clears sequencer and valid flags
// element stores are not cleared by reset and hold their contents across runs
`timescale 1ns / 1ps

module matrix_multiply_4x4
   import mm4_pkg::*;
#(
   parameter int DIM = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   // load channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // elem_index, a_value, b_value, zero pad
   input  logic                  req_tlast,   // load_done
   // product channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // out_row, out_col, product_value, zero pad
   output logic                  rsp_tlast    // out_last
);

   localparam int CELLS = DIM * DIM;
   localparam int CELL_W = $clog2(CELLS);
   localparam int CNT_W = $clog2(DIM);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(DIM - 1);

   // unpacked load fields
   logic [IDX_W-1:0]  elem_index;
   logic [VAL_W-1:0]  a_value;
   logic [VAL_W-1:0]  b_value;

   assign elem_index = req_tdata[IDX_W-1:0];
   assign a_value    = req_tdata[IDX_W+VAL_W-1:IDX_W];
   assign b_value    = req_tdata[IDX_W+2*VAL_W-1:IDX_W+VAL_W];

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] row_ff, row_in;
   logic [CNT_W-1:0] col_ff, col_in;
   logic [CNT_W-1:0] k_ff, k_in;
   mm4_tag_type      tag1_ff, tag1_in;
   mm4_tag_type      issue_tag;
   mm4_result_type   rsp_ff, rsp_in;
   mm4_result_type   result;

   logic             adv;
   logic             req_xfer;
   logic             wr_en;
   logic [CELL_W-1:0] rd_a_addr;
   logic [CELL_W-1:0] rd_b_addr;
   logic [VAL_W-1:0] rd_a_data;
   logic [VAL_W-1:0] rd_b_data;
   logic             k_end, col_end, row_end;

   // the whole unit moves only when the output register can take a result
   assign adv        = !rsp_ff.valid || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;

   // out-of-range indexes are dropped, tlast still starts the run
   assign wr_en = req_xfer && (32'(elem_index) < 32'(CELLS));

   // a[row][k] and b[k][col]
   assign rd_a_addr = CELL_W'(int'(row_ff) * DIM + int'(k_ff));
   assign rd_b_addr = CELL_W'(int'(k_ff) * DIM + int'(col_ff));

   assign k_end   = (k_ff == CNT_MAX);
   assign col_end = (col_ff == CNT_MAX);
   assign row_end = (row_ff == CNT_MAX);

   always_comb begin
      issue_tag.valid   = (state_ff == ST_RUN);
      issue_tag.first   = (k_ff == '0);
      issue_tag.last    = k_end;
      issue_tag.run_end = k_end && col_end && row_end;
      issue_tag.row     = RC_W'(row_ff);
      issue_tag.col     = RC_W'(col_ff);
   end

   // sequencer: walks row, col and k over the shared unit
   always_comb begin
      state_in = state_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      k_in     = k_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer && req_tlast) begin
               state_in = ST_RUN;
               row_in   = '0;
               col_in   = '0;
               k_in     = '0;
            end
         end
         ST_RUN: begin
            if (adv) begin
               if (k_end) begin
                  k_in = '0;
                  if (col_end) begin
                     col_in = '0;
                     if (row_end) begin
                        state_in = ST_DRAIN;
                     end else begin
                        row_in = row_ff + 1'b1;
                     end
                  end else begin
                     col_in = col_ff + 1'b1;
                  end
               end else begin
                  k_in = k_ff + 1'b1;
               end
            end
         end
         ST_DRAIN: begin
            // back to loading once the final product sits in the output register
            if (adv && result.valid && result.last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         row_ff   <= '0;
         col_ff   <= '0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         k_ff     <= k_in;
      end
   end

   // tag stays aligned with the registered store read
   assign tag1_in = adv ? issue_tag : tag1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff <= '0;
      end else begin
         tag1_ff <= tag1_in;
      end
   end

   mm4_store #(
      .DEPTH (CELLS),
      .AW    (CELL_W)
   ) u_store (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (CELL_W'(elem_index)),
      .wr_a      (a_value),
      .wr_b      (b_value),
      .rd_en     (adv),
      .rd_a_addr (rd_a_addr),
      .rd_b_addr (rd_b_addr),
      .rd_a_data (rd_a_data),
      .rd_b_data (rd_b_data)
   );

   mm4_mac #(
      .DIM (DIM)
   ) u_mac (
      .clock  (clock),
      .reset  (reset),
      .adv    (adv),
      .tag    (tag1_ff),
      .a_data (rd_a_data),
      .b_data (rd_b_data),
      .result (result)
   );

   // output register: takes a finished element whenever the unit moves
   always_comb begin
      rsp_in = rsp_ff;
      if (adv) begin
         rsp_in = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_ff.valid <= 1'b0;
      end else begin
         rsp_ff.valid <= rsp_in.valid;
      end
      rsp_ff.last  <= rsp_in.last;
      rsp_ff.row   <= rsp_in.row;
      rsp_ff.col   <= rsp_in.col;
      rsp_ff.value <= rsp_in.value;
   end

   assign rsp_tvalid = rsp_ff.valid;
   assign rsp_tlast  = rsp_ff.last;
   assign rsp_tdata  = {{(RSP_DATA_W-VAL_W-2*RC_W){1'b0}},
                        rsp_ff.value, rsp_ff.col, rsp_ff.row};

endmodule
